/* hdl/hsl2rgb_pkg.sv */
// hsl2rgb_pkg: shared widths, defaults and types for the HSL to RGB converter.
// No dependencies; compiled first.
package hsl2rgb_pkg;

  // Field widths of the input and result items
  localparam int IN_W   = 16;
  localparam int CH_W   = 8;
  localparam int PACK_W = 24;

  // Default internal fraction width
  localparam int FRAC_BITS_DEF = 16;

  // Three color channels: red, green, blue
  localparam int NUM_CH = 3;

  // Piece of the hue ramp that a channel falls on
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

endpackage

/* hdl/hsl2rgb_if.sv */
// hsl2rgb_if: valid/ready channel interfaces for the HSL input and RGB result.
// Depends on hsl2rgb_pkg for the field widths.

// HSL input channel
interface hsl2rgb_in_if;
  logic                          valid;
  logic                          ready;
  logic [hsl2rgb_pkg::IN_W-1:0]  hue;
  logic [hsl2rgb_pkg::IN_W-1:0]  saturation;
  logic [hsl2rgb_pkg::IN_W-1:0]  lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

// RGB result channel
interface hsl2rgb_out_if;
  logic                           valid;
  logic                           ready;
  logic [hsl2rgb_pkg::CH_W-1:0]   red;
  logic [hsl2rgb_pkg::CH_W-1:0]   green;
  logic [hsl2rgb_pkg::CH_W-1:0]   blue;
  logic [hsl2rgb_pkg::PACK_W-1:0] packed_color;

  modport source (output valid, red, green, blue, packed_color, input ready);
  modport sink   (input valid, red, green, blue, packed_color, output ready);
endinterface

/* hdl/hsl_to_rgb_converter_top.sv */
// hsl_to_rgb_converter_top: five-stage pipelined HSL to RGB converter.
// Depends on hsl2rgb_pkg and the channel interfaces in hsl2rgb_if.sv.
//
// Converts one HSL pixel (Q0.16 hue, saturation, lightness) per clock, while
// the result side is not stalled, into 8-bit red, green and blue plus the
// packed 24-bit word. Throughput is one transfer per cycle unless the result
// side holds off; a result passes through the five register stages (product
// s*l, levels and hue pieces, ramp products, ramp select, scale by 255).
// Back-pressure on the result side stalls only the stages that hold data, so
// bubbles are squeezed out.
// FRAC_BITS (8..24) sets the internal fraction width; the output at
// FRAC_BITS = 16 matches the standard fixed-point formula exactly.
module hsl_to_rgb_converter_top #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  hsl2rgb_in_if.sink    in_hsl,
  hsl2rgb_out_if.source out_rgb
);

  localparam int W      = FRAC_BITS;
  localparam int NCH    = hsl2rgb_pkg::NUM_CH;
  localparam int IN_W   = hsl2rgb_pkg::IN_W;
  localparam int CH_W   = hsl2rgb_pkg::CH_W;

  localparam int unsigned ONE_I        = 1 << FRAC_BITS;
  localparam int unsigned THIRD_I      = ONE_I / 3;
  localparam int unsigned TWO_THIRDS_I = (2 * ONE_I) / 3;

  localparam logic [W-1:0] TWO_THIRDS = W'(TWO_THIRDS_I);
  localparam logic [W+2:0] ONE_X      = (W+3)'(ONE_I);
  localparam logic [W+1:0] TWO_ONE_X  = (W+2)'(2 * ONE_I);
  localparam logic [W+2:0] SIX_X      = (W+3)'(6);
  localparam logic [W+8:0] SCALE_X    = (W+9)'(255);

  // Hue offsets: red +1/3, green 0, blue -1/3 (mod one)
  localparam logic [W-1:0] HUE_OFF [NCH] = '{
    W'(THIRD_I), W'(0), W'(ONE_I - THIRD_I)
  };

  // Stage handshake
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic va_r, vb_r, vc_r, vd_r, ve_r;

  assign rdy_e = !ve_r || out_rgb.ready;
  assign rdy_d = !vd_r || rdy_e;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign in_hsl.ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_hsl.valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) ve_r <= vd_r;
    end
  end

  // Input format conversion to W fraction bits
  logic [W-1:0] h_in, s_in, l_in;

  if (FRAC_BITS >= IN_W) begin : g_widen
    assign h_in = W'(in_hsl.hue)        << (FRAC_BITS - IN_W);
    assign s_in = W'(in_hsl.saturation) << (FRAC_BITS - IN_W);
    assign l_in = W'(in_hsl.lightness)  << (FRAC_BITS - IN_W);
  end else begin : g_narrow
    assign h_in = W'(in_hsl.hue        >> (IN_W - FRAC_BITS));
    assign s_in = W'(in_hsl.saturation >> (IN_W - FRAC_BITS));
    assign l_in = W'(in_hsl.lightness  >> (IN_W - FRAC_BITS));
  end

  // Stage A: product s*l
  logic [2*W-1:0] sl_prod;
  logic [W-1:0]   p_nxt;
  logic [W-1:0]   ha_r, sa_r, la_r, pa_r;

  assign sl_prod = s_in * l_in;
  assign p_nxt   = sl_prod[2*W-1:W];

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      ha_r <= h_in;
      sa_r <= s_in;
      la_r <= l_in;
      pa_r <= p_nxt;
    end
  end

  // Stage B: upper and lower levels, hue point and ramp piece per channel
  logic [W+1:0]              hi_wide;
  logic [W:0]                hi_nxt, lo_nxt, span_nxt;
  logic [W:0]                hib_r, lob_r, spanb_r;
  logic [W:0]                t_nxt   [NCH];
  hsl2rgb_pkg::seg_t         seg_nxt [NCH];
  logic [W:0]                tb_r    [NCH];
  hsl2rgb_pkg::seg_t         segb_r  [NCH];

  always_comb begin
    if (!la_r[W-1]) begin
      hi_wide = {2'b0, la_r} + {2'b0, pa_r};
    end else begin
      hi_wide = {2'b0, la_r} + {2'b0, sa_r} - {2'b0, pa_r};
    end
    hi_nxt   = hi_wide[W:0];
    lo_nxt   = {la_r, 1'b0} - hi_nxt;
    span_nxt = hi_nxt - lo_nxt;
  end

  always_comb begin
    logic [W-1:0] v;
    logic [W-1:0] d;
    logic [W+2:0] v6;
    logic [W+2:0] d6;
    logic [W+1:0] v3;
    for (int c = 0; c < NCH; c++) begin
      v  = ha_r + HUE_OFF[c];
      d  = TWO_THIRDS - v;
      v6 = {3'b0, v} * SIX_X;
      d6 = {3'b0, d} * SIX_X;
      v3 = {2'b0, v} + {1'b0, v, 1'b0};
      t_nxt[c] = d6[W:0];
      if (v6 < ONE_X) begin
        seg_nxt[c] = hsl2rgb_pkg::SEG_RISE;
        t_nxt[c]   = v6[W:0];
      end else if (!v[W-1]) begin
        seg_nxt[c] = hsl2rgb_pkg::SEG_HIGH;
      end else if (v3 < TWO_ONE_X) begin
        seg_nxt[c] = hsl2rgb_pkg::SEG_FALL;
      end else begin
        seg_nxt[c] = hsl2rgb_pkg::SEG_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      hib_r   <= hi_nxt;
      lob_r   <= lo_nxt;
      spanb_r <= span_nxt;
      for (int c = 0; c < NCH; c++) begin
        tb_r[c]   <= t_nxt[c];
        segb_r[c] <= seg_nxt[c];
      end
    end
  end

  // Stage C: ramp products span*t
  logic [W:0]        rise_nxt [NCH];
  logic [W:0]        hic_r, loc_r;
  logic [W:0]        risec_r  [NCH];
  hsl2rgb_pkg::seg_t segc_r   [NCH];

  always_comb begin
    logic [2*W+1:0] prod;
    for (int c = 0; c < NCH; c++) begin
      prod        = spanb_r * tb_r[c];
      rise_nxt[c] = prod[2*W:W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      hic_r <= hib_r;
      loc_r <= lob_r;
      for (int c = 0; c < NCH; c++) begin
        risec_r[c] <= rise_nxt[c];
        segc_r[c]  <= segb_r[c];
      end
    end
  end

  // Stage D: select the ramp level
  logic [W:0] ramp_nxt  [NCH];
  logic [W:0] rampd_r   [NCH];

  always_comb begin
    logic [W+1:0] sum;
    for (int c = 0; c < NCH; c++) begin
      sum = {1'b0, loc_r} + {1'b0, risec_r[c]};
      case (segc_r[c]) inside
        hsl2rgb_pkg::SEG_RISE,
        hsl2rgb_pkg::SEG_FALL: ramp_nxt[c] = sum[W:0];
        hsl2rgb_pkg::SEG_HIGH: ramp_nxt[c] = hic_r;
        default:               ramp_nxt[c] = loc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      for (int c = 0; c < NCH; c++) begin
        rampd_r[c] <= ramp_nxt[c];
      end
    end
  end

  // Stage E: scale by 255, saturate, output register
  logic [CH_W-1:0] ch_nxt [NCH];
  logic [CH_W-1:0] che_r  [NCH];

  always_comb begin
    logic [W+8:0] scaled;
    logic [8:0]   c9;
    for (int c = 0; c < NCH; c++) begin
      scaled    = {8'b0, rampd_r[c]} * SCALE_X;
      c9        = scaled[W+8:W];
      ch_nxt[c] = c9[8] ? {CH_W{1'b1}} : c9[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      for (int c = 0; c < NCH; c++) begin
        che_r[c] <= ch_nxt[c];
      end
    end
  end

  // Result channel
  assign out_rgb.valid        = ve_r;
  assign out_rgb.red          = che_r[0];
  assign out_rgb.green        = che_r[1];
  assign out_rgb.blue         = che_r[2];
  assign out_rgb.packed_color = {che_r[0], che_r[1], che_r[2]};

endmodule
